@@ rtl/core/dpts_pkg.sv @@
package dpts_pkg;

    // request kinds on the input stream
    localparam logic [1:0] KIND_READY  = 2'd0;
    localparam logic [1:0] KIND_SELECT = 2'd1;
    localparam logic [1:0] KIND_TRANS  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [1:0] STATUS_EMPTY    = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_ORDER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRIORITY_COUNT = 1'd1;

    // field widths
    localparam int unsigned TASK_W   = 3;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned COUNT_W  = 4;
    localparam int unsigned SLOT_MAX = 8;
    localparam int unsigned ORDER_W  = SLOT_MAX * TASK_W;
    localparam int unsigned IN_W     = 8;
    localparam int unsigned OUT_W    = 16;

    // configuration reset values
    localparam logic [ORDER_W-1:0] ORDER_RESET = 24'd16434824;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

    typedef enum logic
    {
        S_IDLE,
        S_EXEC
    } state_t;

    // command from the sequencer to every queue cell
    typedef struct packed
    {
        logic [TASK_W-1:0] want;
        logic [TASK_W-1:0] new_id;
        logic              append;
        logic              remove;
        logic              fcfs;
    } cell_cmd_t;

    // result word, chosen_task in the lowest bits
    typedef struct packed
    {
        logic [COUNT_W-1:0] ready_count;
        logic [1:0]         status;
        logic               by_priority;
        logic               chosen_valid;
        logic [TASK_W-1:0]  chosen_task;
    } result_t;

endpackage

@@ rtl/core/dynamic_priority_task_selector.sv @@
// sequencing: a ready, transition or unused request has its result registered in the exec
// state after acceptance, once the output is free; a select first passes over s priority
// slots, up to min(priority_count, NUM_TASKS, 8), one slot matched against the cell chain
// per cycle, then registers its result once the output is free
// throughput: one request in flight; the next is accepted the cycle after the result is registered
// reset: sequencer idle, queue empty, no yield, config at defaults; cells not cleared
module dynamic_priority_task_selector #(
    parameter int unsigned NUM_TASKS   = 8,
    parameter int unsigned READY_DEPTH = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // task_id [2:0], zero [7:3]
    input  logic [dpts_pkg::IN_W-1:0]      s_axis_tdata,
    // kind [1:0]
    input  logic [dpts_pkg::KIND_W-1:0]    s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // chosen_task [2:0], chosen_valid [3], by_priority [4], status [6:5],
    // ready_count [10:7], zero [15:11]
    output logic [dpts_pkg::OUT_W-1:0]     m_axis_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dpts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dpts_pkg::ORDER_W-1:0]   cfg_data
);
    import dpts_pkg::*;

    localparam int unsigned FILL_W = $clog2(READY_DEPTH + 1);

    cell_cmd_t               cmd;
    logic [FILL_W-1:0]       fill;
    result_t                 result;
    logic [READY_DEPTH:0]    found;
    logic [TASK_W-1:0]       entry [READY_DEPTH];

    assign cfg_ready = 1'b1;
    assign found[0]  = 1'b0;

    // request sequencer and result register
    dpts_ctrl #(
        .NUM_TASKS   (NUM_TASKS),
        .READY_DEPTH (READY_DEPTH),
        .FILL_W      (FILL_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_kind    (s_axis_tuser),
        .in_task    (s_axis_tdata[TASK_W-1:0]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .fill       (fill),
        .chain_hit  (found[READY_DEPTH]),
        .head_entry (entry[0])
    );

    // ready queue as a row of cells, oldest at index 0
    for (genvar i = 0; i < READY_DEPTH; i++)
    begin : g_cell
        logic [TASK_W-1:0] next_entry;

        if (i == READY_DEPTH - 1)
        begin : g_tail
            assign next_entry = entry[i];
        end
        else
        begin : g_body
            assign next_entry = entry[i+1];
        end

        dpts_cell #(
            .INDEX  (i),
            .FILL_W (FILL_W)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .fill       (fill),
            .next_entry (next_entry),
            .found_in   (found[i]),
            .found_out  (found[i+1]),
            .entry      (entry[i])
        );
    end

    assign m_axis_tdata = OUT_W'(result);

endmodule

@@ rtl/core/dpts_cell.sv @@
module dpts_cell #(
    parameter int unsigned INDEX  = 0,
    parameter int unsigned FILL_W = 4
) (
    input  logic                      clk,
    input  dpts_pkg::cell_cmd_t       cmd,
    input  logic [FILL_W-1:0]         fill,
    input  logic [dpts_pkg::TASK_W-1:0] next_entry,
    input  logic                      found_in,
    output logic                      found_out,
    output logic [dpts_pkg::TASK_W-1:0] entry
);
    import dpts_pkg::*;

    logic [TASK_W-1:0] entry_reg;
    logic              occupied;
    logic              hit_here;
    logic              take_next;

    // match against the wanted id, oldest hit wins down the chain
    assign occupied  = fill > FILL_W'(INDEX);
    assign hit_here  = occupied && (entry_reg == cmd.want);
    assign found_out = found_in || hit_here;

    // cells at and behind the removed entry pull from their neighbor
    assign take_next = cmd.remove && (cmd.fcfs || found_out);

    // entry storage
    always_ff @(posedge clk)
    begin
        if (cmd.append && (fill == FILL_W'(INDEX)))
        begin
            entry_reg <= cmd.new_id;
        end
        else if (take_next)
        begin
            entry_reg <= next_entry;
        end
    end

    assign entry = entry_reg;

endmodule

@@ rtl/core/dpts_ctrl.sv @@
module dpts_ctrl #(
    parameter int unsigned NUM_TASKS   = 8,
    parameter int unsigned READY_DEPTH = 8,
    parameter int unsigned FILL_W      = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [dpts_pkg::KIND_W-1:0]   in_kind,
    input  logic [dpts_pkg::TASK_W-1:0]   in_task,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dpts_pkg::result_t             out_result,
    input  logic                          cfg_valid,
    input  logic [dpts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dpts_pkg::ORDER_W-1:0]  cfg_data,
    output dpts_pkg::cell_cmd_t           cmd,
    output logic [FILL_W-1:0]             fill,
    input  logic                          chain_hit,
    input  logic [dpts_pkg::TASK_W-1:0]   head_entry
);
    import dpts_pkg::*;

    localparam int unsigned SLOT_LIMIT = (NUM_TASKS < SLOT_MAX) ? NUM_TASKS : SLOT_MAX;
    localparam int unsigned SLOT_IDX_W = $clog2(SLOT_MAX);

    state_t                          state_reg, state_next;
    logic [KIND_W-1:0]               kind_reg;
    logic [TASK_W-1:0]               tid_reg;
    logic [COUNT_W-1:0]              slot_reg, slot_next;
    logic [FILL_W-1:0]               fill_reg, fill_next;
    logic [TASK_W-1:0]               yield_task_reg, yield_task_next;
    logic                            yield_valid_reg, yield_valid_next;
    logic [TASK_W-1:0]               last_sel_reg, last_sel_next;
    logic [SLOT_MAX-1:0][TASK_W-1:0] order_reg;
    logic [COUNT_W-1:0]              count_reg;
    logic                            out_valid_reg, out_valid_next;
    result_t                         out_result_reg, out_result_next;

    logic               out_free;
    logic               out_load;
    logic [COUNT_W-1:0] slot_lim;
    logic [TASK_W-1:0]  want;
    logic               skip;

    assign out_free = !out_valid_reg || out_ready;
    assign slot_lim = (count_reg > COUNT_W'(SLOT_LIMIT)) ? COUNT_W'(SLOT_LIMIT) : count_reg;
    assign want     = order_reg[slot_reg[SLOT_IDX_W-1:0]];
    assign skip     = yield_valid_reg && (want == yield_task_reg);

    // sequencer: one request at a time, select scans one slot a cycle
    always_comb
    begin
        state_next       = state_reg;
        slot_next        = slot_reg;
        fill_next        = fill_reg;
        yield_task_next  = yield_task_reg;
        yield_valid_next = yield_valid_reg;
        last_sel_next    = last_sel_reg;
        out_load         = 1'b0;
        out_result_next  = out_result_reg;
        cmd.want         = want;
        cmd.new_id       = tid_reg;
        cmd.append       = 1'b0;
        cmd.remove       = 1'b0;
        cmd.fcfs         = 1'b0;
        in_ready         = (state_reg == S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    slot_next  = '0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                out_result_next = '0;
                case (kind_reg)
                    KIND_READY:
                    begin
                        if (out_free)
                        begin
                            out_load = 1'b1;
                            if (fill_reg < FILL_W'(READY_DEPTH))
                            begin
                                cmd.append = 1'b1;
                                fill_next  = fill_reg + 1'b1;
                            end
                            else
                            begin
                                out_result_next.status = STATUS_OVERFLOW;
                            end
                        end
                    end
                    KIND_SELECT:
                    begin
                        if (fill_reg == '0)
                        begin
                            out_load               = out_free;
                            out_result_next.status = STATUS_EMPTY;
                        end
                        else if (slot_reg >= slot_lim)
                        begin
                            // no slot matched, take the oldest entry
                            if (out_free)
                            begin
                                out_load                     = 1'b1;
                                cmd.remove                   = 1'b1;
                                cmd.fcfs                     = 1'b1;
                                fill_next                    = fill_reg - 1'b1;
                                last_sel_next                = head_entry;
                                yield_valid_next             = 1'b0;
                                out_result_next.chosen_task  = head_entry;
                                out_result_next.chosen_valid = 1'b1;
                            end
                        end
                        else if (!skip && chain_hit)
                        begin
                            if (out_free)
                            begin
                                out_load                     = 1'b1;
                                cmd.remove                   = 1'b1;
                                fill_next                    = fill_reg - 1'b1;
                                last_sel_next                = want;
                                yield_valid_next             = 1'b0;
                                out_result_next.chosen_task  = want;
                                out_result_next.chosen_valid = 1'b1;
                                out_result_next.by_priority  = 1'b1;
                            end
                        end
                        else
                        begin
                            slot_next = slot_reg + 1'b1;
                        end
                    end
                    KIND_TRANS:
                    begin
                        if (out_free)
                        begin
                            out_load         = 1'b1;
                            yield_task_next  = last_sel_reg;
                            yield_valid_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        out_load = out_free;
                    end
                endcase
                out_result_next.ready_count = COUNT_W'(fill_next);
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            slot_reg        <= '0;
            fill_reg        <= '0;
            yield_task_reg  <= '0;
            yield_valid_reg <= 1'b0;
            last_sel_reg    <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            slot_reg        <= slot_next;
            fill_reg        <= fill_next;
            yield_task_reg  <= yield_task_next;
            yield_valid_reg <= yield_valid_next;
            last_sel_reg    <= last_sel_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            order_reg <= ORDER_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PRIORITY_ORDER: order_reg <= cfg_data;
                REG_PRIORITY_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:            count_reg <= count_reg;
            endcase
        end
    end

    // captured request and result payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg <= in_kind;
            tid_reg  <= in_task;
        end
        if (out_load)
        begin
            out_result_reg <= out_result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;
    assign fill       = fill_reg;

endmodule

@@ rtl/core/dpts_checker.sv @@
module dpts_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [dpts_pkg::OUT_W-1:0] m_axis_tdata
);
    import dpts_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // a chosen task always comes with ok status
    a_chosen_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[6:5] == STATUS_OK)
        else $error("chosen task with error status");

    // priority choice only on a valid choice
    a_prio_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3])
        else $error("by_priority without chosen task");

    // an empty select leaves the queue empty
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[6:5] == STATUS_EMPTY |-> m_axis_tdata[10:7] == '0)
        else $error("empty select with nonzero count");

endmodule

bind dynamic_priority_task_selector dpts_checker u_dpts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    import dpts_pkg::*;

    // kind code that the block ignores
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam int unsigned QUEUE_DEPTH = 8;
    localparam int unsigned STALL_LIMIT = 1000;
    localparam int unsigned PHASE_ITEMS = 200;
    localparam int unsigned NUM_PHASES = 6;

    // tracks the scheduler state and the results it must produce
    class sched_tracker;
        logic [TASK_W-1:0]  ready_ids[QUEUE_DEPTH];
        int unsigned        fill;
        logic [TASK_W-1:0]  yield_id;
        bit                 yield_on;
        logic [TASK_W-1:0]  last_pick;
        logic [ORDER_W-1:0] order;
        logic [COUNT_W-1:0] slot_cnt;
        result_t            expected_results[$];
        int                 fail_count;

        function new();
            fill = 0;
            yield_id = '0;
            yield_on = 1'b0;
            last_pick = '0;
            order = ORDER_RESET;
            slot_cnt = COUNT_RESET;
            fail_count = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [ORDER_W-1:0] data);
            if (idx == REG_PRIORITY_ORDER)
                order = data;
            else
                slot_cnt = data[COUNT_W-1:0];
        endfunction

        // remove one entry and close the gap
        function void take_entry(int unsigned pos);
            int unsigned j;
            for (j = pos; j + 1 < fill; j++)
                ready_ids[j] = ready_ids[j + 1];
            fill--;
        endfunction

        // work out the result of one accepted request
        function void note_request(logic [1:0] kind, logic [TASK_W-1:0] tid);
            result_t           r;
            int unsigned       slots;
            int unsigned       s;
            int unsigned       i;
            bit                found;
            logic [TASK_W-1:0] want;
            r = '0;
            case (kind)
                KIND_READY:
                begin
                    if (fill < QUEUE_DEPTH)
                    begin
                        ready_ids[fill] = tid;
                        fill++;
                    end
                    else
                        r.status = STATUS_OVERFLOW;
                end
                KIND_SELECT:
                begin
                    if (fill == 0)
                        r.status = STATUS_EMPTY;
                    else
                    begin
                        slots = (slot_cnt > SLOT_MAX) ? SLOT_MAX : slot_cnt;
                        found = 1'b0;
                        // first usable slot with a queued match wins, oldest entry first
                        for (s = 0; s < slots && !found; s++)
                        begin
                            want = order[3*s +: 3];
                            if (yield_on && want == yield_id)
                                continue;
                            for (i = 0; i < fill && !found; i++)
                            begin
                                if (ready_ids[i] == want)
                                begin
                                    found = 1'b1;
                                    r.chosen_task = want;
                                    r.by_priority = 1'b1;
                                    take_entry(i);
                                end
                            end
                        end
                        // fall back to arrival order
                        if (!found)
                        begin
                            r.chosen_task = ready_ids[0];
                            take_entry(0);
                        end
                        r.chosen_valid = 1'b1;
                        last_pick = r.chosen_task;
                        yield_on = 1'b0;
                    end
                end
                KIND_TRANS:
                begin
                    yield_id = last_pick;
                    yield_on = 1'b1;
                end
                default:
                begin
                end
            endcase
            r.ready_count = fill[COUNT_W-1:0];
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void compare_field(string name, int exp_val, int act_val);
            if (exp_val != act_val)
            begin
                $display("%0t: mismatch in %s: expected %0d, actual %0d",
                         $time, name, exp_val, act_val);
                fail_count++;
            end
        endfunction

        // compare one accepted result with the oldest expectation
        function void check_result(logic [OUT_W-1:0] word);
            result_t got;
            result_t exp;
            got = word[$bits(result_t)-1:0];
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, word);
                fail_count++;
                return;
            end
            exp = expected_results[0];
            expected_results.delete(0);
            compare_field("chosen_task", exp.chosen_task, got.chosen_task);
            compare_field("chosen_valid", exp.chosen_valid, got.chosen_valid);
            compare_field("by_priority", exp.by_priority, got.by_priority);
            compare_field("status", exp.status, got.status);
            compare_field("ready_count", exp.ready_count, got.ready_count);
            compare_field("pad bits", 0, word[OUT_W-1:$bits(result_t)]);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic [KIND_W-1:0]    s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ORDER_W-1:0]   cfg_data;

    sched_tracker tracker;
    bit           no_idle;
    bit           sender_idle_on;
    int unsigned  stall_left;
    int unsigned  quiet_cycles;

    dynamic_priority_task_selector uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver with random stall bursts
    initial
    begin
        m_axis_tready <= 1'b0;
        stall_left = 0;
    end

    always @(posedge clk)
    begin
        if (no_idle)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left = $urandom_range(1, 6) - 1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // monitor: predict on accepted requests, check accepted results
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            tracker.check_result(m_axis_tdata);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            tracker.note_request(s_axis_tuser, s_axis_tdata[TASK_W-1:0]);
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     tracker.expected_results.size());
            $display("status: fail");
            $finish;
        end
    end

    // send one request, then an optional gap
    task automatic send_request(logic [1:0] kind, logic [TASK_W-1:0] tid);
        int unsigned gap;
        gap = (!no_idle && sender_idle_on && $urandom_range(0, 3) == 0) ?
              $urandom_range(1, 6) : 0;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {5'b00000, tid};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold the sender until every expected result is in
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.expected_results.size() != 0);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ORDER_W-1:0] data);
        wait_drained();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        tracker.write_reg(idx, data);
    endtask

    // random kind with a given share of ready requests
    function automatic logic [1:0] pick_kind(int unsigned ready_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
            return KIND_UNUSED;
        else if (r < 3 + ready_pct)
            return KIND_READY;
        else if (r < 88)
            return KIND_SELECT;
        else
            return KIND_TRANS;
    endfunction

    // stimulus
    initial
    begin
        int unsigned        phase;
        int unsigned        n;
        logic [ORDER_W-1:0] order_val;
        logic [ORDER_W-1:0] count_val;
        int unsigned        ready_pct;

        tracker = new();
        no_idle = 1'b0;
        sender_idle_on = 1'b1;
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tuser <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty select, early transition, unused kind, fill and overflow
        send_request(KIND_SELECT, 3'd0);
        send_request(KIND_TRANS, 3'd5);
        send_request(KIND_UNUSED, 3'd7);
        send_request(KIND_READY, 3'd0);
        send_request(KIND_READY, 3'd7);
        send_request(KIND_READY, 3'd3);
        send_request(KIND_READY, 3'd3);
        send_request(KIND_READY, 3'd5);
        send_request(KIND_READY, 3'd1);
        send_request(KIND_READY, 3'd6);
        send_request(KIND_READY, 3'd2);
        send_request(KIND_READY, 3'd4);
        // priority picks, yield skip and duplicates
        send_request(KIND_SELECT, 3'd7);
        send_request(KIND_TRANS, 3'd0);
        send_request(KIND_READY, 3'd0);
        send_request(KIND_SELECT, 3'd0);
        send_request(KIND_SELECT, 3'd0);
        send_request(KIND_TRANS, 3'd2);
        send_request(KIND_SELECT, 3'd0);
        send_request(KIND_SELECT, 3'd0);
        // zero slots forces arrival order
        write_register(REG_PRIORITY_COUNT, 24'd0);
        send_request(KIND_READY, 3'd3);
        send_request(KIND_SELECT, 3'd0);
        // all slots name one task, count above range; yielding it falls back
        write_register(REG_PRIORITY_ORDER, 24'hFFFFFF);
        write_register(REG_PRIORITY_COUNT, {20'($urandom_range(0, (1 << 20) - 1)), 4'd15});
        send_request(KIND_READY, 3'd7);
        send_request(KIND_SELECT, 3'd0);
        send_request(KIND_TRANS, 3'd0);
        send_request(KIND_READY, 3'd7);
        send_request(KIND_SELECT, 3'd0);

        // random phases, each with its own register settings
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            order_val = 24'($urandom_range(0, 24'hFFFFFF));
            count_val = {20'($urandom_range(0, (1 << 20) - 1)), 4'd8};
            case (phase)
                1:
                begin
                    order_val = 24'h000000;
                    count_val[3:0] = 4'd15;
                end
                2:
                begin
                    order_val = 24'hFFFFFF;
                    count_val[3:0] = 4'd0;
                end
                3: count_val[3:0] = 4'($urandom_range(1, 7));
                4: count_val[3:0] = 4'($urandom_range(0, 15));
                default:
                begin
                end
            endcase
            write_register(REG_PRIORITY_ORDER, order_val);
            write_register(REG_PRIORITY_COUNT, count_val);
            if (phase == NUM_PHASES - 1)
                no_idle = 1'b1;
            ready_pct = (phase % 2 == 1) ? 40 : 55;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n % 50 == 0)
                    sender_idle_on = ($urandom_range(0, 2) != 0);
                if (n == PHASE_ITEMS / 2)
                    wait_drained();
                send_request(pick_kind(ready_pct), 3'($urandom_range(0, 7)));
            end
        end

        // drain and let the pipeline settle
        wait_drained();
        repeat (12) @(posedge clk);
        if (tracker.fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

@@ dynamic_priority_task_selector.f @@
rtl/core/dpts_pkg.sv
rtl/core/dpts_cell.sv
rtl/core/dpts_ctrl.sv
rtl/core/dynamic_priority_task_selector.sv
rtl/core/dpts_checker.sv
dv/tb_top.sv
